>>> rtl/spf_pkg.sv
`timescale 1ns / 1ps
// Shared types, state codes and saturation helpers for the steering agent.
package spf_pkg;

  typedef enum logic [5:0] {
    ST_IDLE, ST_OUT,
    ST_SEEK0, ST_SEEK1, ST_SEEK2,
    ST_FOL0, ST_FOL1, ST_FOL2, ST_FOL3, ST_FOL4, ST_FOL5, ST_FOL6, ST_FOL7,
    ST_FOL8, ST_FOL9, ST_FOL10, ST_FOL11, ST_FOL12, ST_FOL13, ST_FOL14, ST_FOL_STEER,
    ST_INT0, ST_INT1,
    ST_V_SQX, ST_V_SQY, ST_V_SUM, ST_V_CHK, ST_V_ROOT,
    ST_V_MX, ST_V_DX, ST_V_WX, ST_V_MY, ST_V_DY, ST_V_WY
  } spf_state_t;

  typedef enum logic [1:0] {
    MODE_INTEGRATE = 2'd0,
    MODE_SEEK      = 2'd1,
    MODE_FOLLOW    = 2'd2,
    MODE_PLACE     = 2'd3
  } spf_mode_t;

  typedef enum logic [2:0] {
    REG_MAX_SPEED    = 3'd0,
    REG_MAX_FORCE    = 3'd1,
    REG_PATH_START_X = 3'd2,
    REG_PATH_START_Y = 3'd3,
    REG_PATH_END_X   = 3'd4,
    REG_PATH_END_Y   = 3'd5,
    REG_PATH_RADIUS  = 3'd6,
    REG_UNUSED       = 3'd7
  } spf_reg_t;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  function automatic logic signed [65:0] sx32(input logic signed [31:0] a);
    return {{34{a[31]}}, a};
  endfunction

  function automatic logic signed [65:0] sx64(input logic signed [63:0] a);
    return {{2{a[63]}}, a};
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic top_zero;
    logic top_ones;
    top_zero = (v[65:31] == '0);
    top_ones = (v[65:31] == '1);
    if (top_zero || top_ones) return v[31:0];
    else if (v[65]) return SAT_MIN;
    else return SAT_MAX;
  endfunction

  // apply the sign to a scaled magnitude, saturating if ovf or q[31] is set; ovf means quotient >= 2^32
  function automatic logic signed [31:0] scale_res(input logic neg, input logic [31:0] q,
                                                   input logic ovf);
    if (!neg) begin
      if (ovf || q[31]) return SAT_MAX;
      else return q;
    end else begin
      if (ovf || q[31]) return SAT_MIN;
      else return -q;
    end
  endfunction

endpackage

>>> rtl/spf_mul.sv
`timescale 1ns / 1ps
// Shared signed 32x32 multiplier with registered product.
module spf_mul
  import spf_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/spf_sqrt.sv
`timescale 1ns / 1ps
// Bitwise integer square root of a 64-bit value, one result bit a cycle.
module spf_sqrt
  import spf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        n    <= radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (n >= trial) begin
          n   <= n - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/spf_div.sv
`timescale 1ns / 1ps
// Restoring divider, 64-bit dividend by 32-bit divisor, 32 quotient bits with overflow flag.
module spf_div
  import spf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic        ovf
);

  logic [31:0] rem;
  logic [31:0] den;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] t;
  logic        ge;

  assign t  = {rem, quot[31]};
  assign ge = (t >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den  <= divisor;
        rem  <= dividend[63:32];
        quot <= dividend[31:0];
        cnt  <= '0;
        // high half not below divisor: quotient needs more than 32 bits
        if (dividend[63:32] >= divisor) begin
          ovf  <= 1'b1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          ovf  <= 1'b0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (ge) rem <= 32'(t - {1'b0, den});
        else rem <= t[31:0];
        quot <= {quot[30:0], ge};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/steering_path_follow_agent_top.sv
`timescale 1ns / 1ps
// Top level of the path-following steering agent: sequencer and state.
//
//  channel   | dir | signals                          | carries
//  ----------+-----+----------------------------------+----------------------------------
//  s_axis    | in  | tvalid tready tdata[71:0]        | one tick: mode, target_x, target_y
//  m_axis    | out | tvalid tready tdata[135:0]       | pos_x, pos_y, vel_x, vel_y, steered
//  cfg       | in  | cfg_we cfg_index[2:0] cfg_data   | register write, no read-back
//
// The time per tick depends on the mode and is set by the vector normalise/limit routine:
// it returns early for a zero vector or one already within its limit, and otherwise
// takes a square root and two divisions.
// One tick at a time: s_axis_tready is high only while the sequencer is idle.
// The result register frees the sequencer, so a new transfer is taken while a result waits.
// Reset (rst, synchronous) clears agent state and loads register defaults.
module steering_path_follow_agent_top
  import spf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // mode[1:0], target_x[33:2], target_y[65:34], zero
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // pos_x, pos_y, vel_x, vel_y, steered[128], zero
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic signed [31:0] L_HALF   = 32'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] L_ONE    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] L_AHEAD  = 32'sd25 <<< FRAC_BITS;
  localparam logic signed [31:0] L_PUSH   = 32'sd10 <<< FRAC_BITS;
  localparam logic [30:0]        SPD_INIT = 31'(50 << FRAC_BITS);
  localparam logic [30:0]        FRC_INIT = 31'(5 << FRAC_BITS);

  // configuration
  logic [30:0]        max_speed, max_force, path_radius;
  logic signed [31:0] path_start_x, path_start_y, path_end_x, path_end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed    <= SPD_INIT;
      max_force    <= FRC_INIT;
      path_radius  <= '0;
      path_start_x <= '0;
      path_start_y <= '0;
      path_end_x   <= '0;
      path_end_y   <= '0;
    end else if (cfg_we) begin
      unique case (spf_reg_t'(cfg_index))
        REG_MAX_SPEED:    max_speed    <= cfg_data[30:0];
        REG_MAX_FORCE:    max_force    <= cfg_data[30:0];
        REG_PATH_START_X: path_start_x <= cfg_data;
        REG_PATH_START_Y: path_start_y <= cfg_data;
        REG_PATH_END_X:   path_end_x   <= cfg_data;
        REG_PATH_END_Y:   path_end_y   <= cfg_data;
        REG_PATH_RADIUS:  path_radius  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // agent state and working registers
  spf_state_t         state, state_next, ret_st;
  logic signed [31:0] position_x, position_y, velocity_x, velocity_y;
  logic signed [31:0] tgt_x, tgt_y, acc_x, acc_y;
  logic               steered;
  logic signed [31:0] vx, vy, vlen, rx, ry;
  logic               vlim;
  logic signed [63:0] acc;
  logic [63:0]        sq;
  logic [31:0]        len;
  logic signed [31:0] lx, ly, apx, apy, abx, aby, ux, uy, dot, nx, ny, dpx, dpy;
  logic signed [33:0] ex, ey;
  logic [33:0]        ex_mag, ey_mag;

  // shared units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] p;
  logic               sqrt_start, sqrt_done;
  logic [31:0]        root;
  logic               div_start, div_done, div_ovf;
  logic [31:0]        quot;
  logic [63:0]        p_mag;
  logic               out_free;

  assign p_mag    = p[63] ? 64'(-p) : 64'(p);
  assign ex_mag   = ex[33] ? 34'(-ex) : 34'(ex);
  assign ey_mag   = ey[33] ? 34'(-ey) : 34'(ey);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  spf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  spf_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sq), .done(sqrt_done), .root(root)
  );

  spf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(p_mag), .divisor(len),
    .done(div_done), .quot(quot), .ovf(div_ovf)
  );

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and shared-unit control
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (spf_mode_t'(s_axis_tdata[1:0]))
            MODE_PLACE:     state_next = ST_OUT;
            MODE_INTEGRATE: state_next = ST_INT0;
            MODE_SEEK:      state_next = ST_SEEK0;
            MODE_FOLLOW:    state_next = ST_FOL0;
            default:        state_next = ST_OUT;
          endcase
        end
      end
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      ST_SEEK0:     state_next = ST_V_SQX;
      ST_SEEK1:     state_next = ST_V_SQX;
      ST_SEEK2:     state_next = ST_INT0;
      ST_FOL0:      state_next = ST_V_SQX;
      ST_FOL1:      state_next = ST_FOL2;
      ST_FOL2:      state_next = ST_V_SQX;
      ST_FOL3:      state_next = ST_FOL4;
      ST_FOL4: begin
        mul_a = apx; mul_b = ux; state_next = ST_FOL5;
      end
      ST_FOL5: begin
        mul_a = apy; mul_b = uy; state_next = ST_FOL6;
      end
      ST_FOL6:      state_next = ST_FOL7;
      ST_FOL7: begin
        mul_a = ux; mul_b = dot; state_next = ST_FOL8;
      end
      ST_FOL8: begin
        mul_a = uy; mul_b = dot; state_next = ST_FOL9;
      end
      ST_FOL9:      state_next = ST_V_SQX;
      ST_FOL10:     state_next = ST_FOL11;
      ST_FOL11: begin
        if (ex_mag > {3'b000, path_radius} || ey_mag > {3'b000, path_radius}) begin
          state_next = ST_FOL_STEER;
        end else begin
          mul_a = ex[31:0]; mul_b = ex[31:0]; state_next = ST_FOL12;
        end
      end
      ST_FOL12: begin
        mul_a = ey[31:0]; mul_b = ey[31:0]; state_next = ST_FOL13;
      end
      ST_FOL13: begin
        mul_a = {1'b0, path_radius}; mul_b = {1'b0, path_radius}; state_next = ST_FOL14;
      end
      ST_FOL14: begin
        if (sq <= 64'(p)) state_next = ST_INT0;
        else state_next = ST_FOL_STEER;
      end
      ST_FOL_STEER: state_next = ST_SEEK0;
      ST_INT0:      state_next = ST_V_SQX;
      ST_INT1:      state_next = ST_OUT;
      // vector normalise / limit routine
      ST_V_SQX: begin
        mul_a = vx; mul_b = vx; state_next = ST_V_SQY;
      end
      ST_V_SQY: begin
        mul_a = vy; mul_b = vy; state_next = ST_V_SUM;
      end
      ST_V_SUM: begin
        mul_a = vlen; mul_b = vlen; state_next = ST_V_CHK;
      end
      ST_V_CHK: begin
        if (vlim && sq <= 64'(p)) state_next = ret_st;
        else if (!vlim && sq == '0) state_next = ret_st;
        else begin
          sqrt_start = 1'b1; state_next = ST_V_ROOT;
        end
      end
      ST_V_ROOT:    if (sqrt_done) state_next = ST_V_MX;
      ST_V_MX: begin
        mul_a = vx; mul_b = vlen; state_next = ST_V_DX;
      end
      ST_V_DX: begin
        div_start = 1'b1; state_next = ST_V_WX;
      end
      ST_V_WX:      if (div_done) state_next = ST_V_MY;
      ST_V_MY: begin
        mul_a = vy; mul_b = vlen; state_next = ST_V_DY;
      end
      ST_V_DY: begin
        div_start = 1'b1; state_next = ST_V_WY;
      end
      ST_V_WY:      if (div_done) state_next = ret_st;
      default:      state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x    <= '0;
      position_y    <= '0;
      velocity_x    <= '0;
      velocity_y    <= '0;
      m_axis_tvalid <= 1'b0;
      steered       <= 1'b0;
      ret_st        <= ST_IDLE;
    end else begin
      // in ST_OUT the result register is reloaded instead
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            tgt_x   <= s_axis_tdata[33:2];
            tgt_y   <= s_axis_tdata[65:34];
            acc_x   <= '0;
            acc_y   <= '0;
            steered <= 1'b0;
            if (spf_mode_t'(s_axis_tdata[1:0]) == MODE_PLACE) begin
              position_x <= s_axis_tdata[33:2];
              position_y <= s_axis_tdata[65:34];
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, steered, velocity_y, velocity_x, position_y, position_x};
          end
        end
        ST_SEEK0: begin
          vx     <= sat32(sx32(tgt_x) - sx32(position_x));
          vy     <= sat32(sx32(tgt_y) - sx32(position_y));
          vlen   <= L_HALF;
          vlim   <= 1'b0;
          ret_st <= ST_SEEK1;
        end
        ST_SEEK1: begin
          vx     <= sat32(sx32(rx) - sx32(velocity_x));
          vy     <= sat32(sx32(ry) - sx32(velocity_y));
          vlen   <= {1'b0, max_force};
          vlim   <= 1'b1;
          ret_st <= ST_SEEK2;
        end
        ST_SEEK2: begin
          acc_x   <= rx;
          acc_y   <= ry;
          steered <= 1'b1;
        end
        ST_FOL0: begin
          vx     <= velocity_x;
          vy     <= velocity_y;
          vlen   <= L_AHEAD;
          vlim   <= 1'b0;
          ret_st <= ST_FOL1;
        end
        ST_FOL1: begin
          lx <= sat32(sx32(rx) + sx32(position_x));
          ly <= sat32(sx32(ry) + sx32(position_y));
        end
        ST_FOL2: begin
          apx    <= sat32(sx32(lx) - sx32(path_start_x));
          apy    <= sat32(sx32(ly) - sx32(path_start_y));
          abx    <= sat32(sx32(path_end_x) - sx32(path_start_x));
          aby    <= sat32(sx32(path_end_y) - sx32(path_start_y));
          vx     <= sat32(sx32(path_end_x) - sx32(path_start_x));
          vy     <= sat32(sx32(path_end_y) - sx32(path_start_y));
          vlen   <= L_ONE;
          vlim   <= 1'b0;
          ret_st <= ST_FOL3;
        end
        ST_FOL3: begin
          ux <= rx;
          uy <= ry;
        end
        ST_FOL5:  acc <= p;
        ST_FOL6:  dot <= sat32((sx64(acc) + sx64(p)) >>> FRAC_BITS);
        ST_FOL8:  nx  <= sat32(sx32(path_start_x) + sx64(p >>> FRAC_BITS));
        ST_FOL9: begin
          ny     <= sat32(sx32(path_start_y) + sx64(p >>> FRAC_BITS));
          vx     <= abx;
          vy     <= aby;
          vlen   <= L_PUSH;
          vlim   <= 1'b0;
          ret_st <= ST_FOL10;
        end
        ST_FOL10: begin
          dpx <= rx;
          dpy <= ry;
          ex  <= 34'(sx32(nx) - sx32(lx));
          ey  <= 34'(sx32(ny) - sx32(ly));
        end
        ST_FOL12: acc <= p;
        ST_FOL13: sq  <= 64'(acc) + 64'(p);
        ST_FOL_STEER: begin
          tgt_x <= sat32(sx32(nx) + sx32(dpx));
          tgt_y <= sat32(sx32(ny) + sx32(dpy));
        end
        ST_INT0: begin
          velocity_x <= sat32(sx32(velocity_x) + sx32(acc_x));
          velocity_y <= sat32(sx32(velocity_y) + sx32(acc_y));
          vx         <= sat32(sx32(velocity_x) + sx32(acc_x));
          vy         <= sat32(sx32(velocity_y) + sx32(acc_y));
          vlen       <= {1'b0, max_speed};
          vlim       <= 1'b1;
          ret_st     <= ST_INT1;
        end
        ST_INT1: begin
          velocity_x <= rx;
          velocity_y <= ry;
          position_x <= sat32(sx32(position_x) + sx32(rx));
          position_y <= sat32(sx32(position_y) + sx32(ry));
        end
        ST_V_SQY: acc <= p;
        ST_V_SUM: sq  <= 64'(acc) + 64'(p);
        ST_V_CHK: begin
          // within limit keeps the vector; zero vector normalises to zero
          if (vlim) begin
            rx <= vx;
            ry <= vy;
          end else begin
            rx <= '0;
            ry <= '0;
          end
        end
        ST_V_ROOT: if (sqrt_done) len <= root;
        ST_V_WX:   if (div_done) rx <= scale_res(vx[31], quot, div_ovf);
        ST_V_WY:   if (div_done) ry <= scale_res(vy[31], quot, div_ovf);
        default: ;
      endcase
    end
  end

endmodule
